// ===== sv/semaphore_wait_queue_table_assert.svh =====
// Assertion macros for the semaphore wait-queue table.
`ifndef SEMAPHORE_WAIT_QUEUE_TABLE_ASSERT_SVH
`define SEMAPHORE_WAIT_QUEUE_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWQT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SWQT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/swqt_pkg.sv =====
`timescale 1ns / 1ps

package swqt_pkg;

    localparam int NUM_DESC   = 32;
    localparam int DESC_BITS  = 5;
    localparam int NUM_BUCKET = 256;
    localparam int BKT_BITS   = 8;
    localparam int KEY_BITS   = 32;
    localparam int PROC_BITS  = 5;

    localparam logic [31:0] HASH_MUL = 32'h61C88647;
    localparam logic [5:0]  LNK_NULL = 6'b100000;

    localparam logic [1:0] OP_BLOCK   = 2'd0;
    localparam logic [1:0] OP_RM_HEAD = 2'd1;
    localparam logic [1:0] OP_RM_PROC = 2'd2;
    localparam logic [1:0] OP_PEEK    = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FREE  = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] sem_key;
        logic [4:0]  proc_id;
    } cmd_t;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] proc_out;
    } result_t;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [5:0]          head;
        logic [5:0]          tail;
        logic [5:0]          chain;
    } desc_t;

endpackage

// ===== sv/semaphore_wait_queue_table.sv =====
// A rejected block or remove-process finishes straight from idle; other operations but a
// remove process hash the key, read the bucket and compare chain entries until one matches.
// After the lookup a peek returns the head, a block allocates or enqueues, a remove head unlinks
// the head; a remove process unlinks its entry, and an emptied queue's descriptor is freed.
// Throughput: one operation at a time, the next transfer is accepted while the result is shown.
// Reset: all queues empty, all descriptors free, no process blocked; usable at once.
`timescale 1ns / 1ps
`include "semaphore_wait_queue_table_assert.svh"

module semaphore_wait_queue_table
    import swqt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  cmd_t    cmd,
    output logic    done,
    output result_t result
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_BKT  = 5'd1;
    localparam logic [4:0] S_LK0  = 5'd2;
    localparam logic [4:0] S_LK1  = 5'd3;
    localparam logic [4:0] S_AL0  = 5'd4;
    localparam logic [4:0] S_AL1  = 5'd5;
    localparam logic [4:0] S_EQ   = 5'd6;
    localparam logic [4:0] S_EQ2  = 5'd7;
    localparam logic [4:0] S_P0   = 5'd8;
    localparam logic [4:0] S_P1   = 5'd9;
    localparam logic [4:0] S_P2   = 5'd10;
    localparam logic [4:0] S_UL   = 5'd11;
    localparam logic [4:0] S_RH   = 5'd12;
    localparam logic [4:0] S_RB   = 5'd13;
    localparam logic [4:0] S_RW0  = 5'd14;
    localparam logic [4:0] S_RW1  = 5'd15;
    localparam logic [4:0] S_FR   = 5'd16;

    desc_t      desc_mem [NUM_DESC];
    logic [5:0] bkt_mem  [NUM_BUCKET];
    logic [5:0] free_mem [NUM_DESC];
    logic [5:0] pn_mem   [NUM_DESC];
    logic [5:0] pp_mem   [NUM_DESC];
    logic [4:0] pd_mem   [NUM_DESC];

    logic [4:0]            state_reg, state_next;
    logic [1:0]            op_reg, op_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [4:0]            q_reg, q_next;
    logic [4:0]            d_reg, d_next;
    logic [4:0]            prev_reg, prev_next;
    logic [5:0]            nx_reg, nx_next;
    logic [5:0]            pr_reg, pr_next;
    logic [5:0]            bkt_reg, bkt_next;
    desc_t                 rec_reg, rec_next;
    logic [BKT_BITS-1:0]   hash_reg, hash_next;
    logic [5:0]            free_head_reg, free_head_next;
    logic [NUM_DESC-1:0]   in_use_reg, in_use_next;
    logic [NUM_DESC-1:0]   blocked_reg, blocked_next;
    logic [NUM_BUCKET-1:0] bvalid_reg, bvalid_next;
    logic [NUM_DESC-1:0]   fvalid_reg, fvalid_next;
    logic                  done_reg, done_next;
    result_t               res_reg, res_next;

    desc_t      drd_reg;
    logic [5:0] brd_reg;
    logic       bsel_reg;
    logic [5:0] frd_reg;
    logic       fsel_reg;
    logic [5:0] pnrd_reg;
    logic [5:0] pprd_reg;
    logic [4:0] pdrd_reg;

    logic [4:0]          d_ra;
    logic                d_we;
    logic [4:0]          d_wa;
    desc_t               d_wd;
    logic                b_we;
    logic [5:0]          b_wd;
    logic                f_we;
    logic                pn_we;
    logic [4:0]          pn_wa;
    logic [5:0]          pn_wd;
    logic                pp_we;
    logic [4:0]          pp_wa;
    logic [5:0]          pp_wd;
    logic                pd_we;
    logic [KEY_BITS-1:0] mul_in;
    logic [31:0]         prod;
    logic [5:0]          bkt_cur;
    logic [5:0]          free_nxt;

    assign mul_in   = (state_reg == S_IDLE) ? cmd.sem_key : rec_reg.key;
    assign prod     = mul_in * HASH_MUL;
    assign bkt_cur  = bsel_reg ? brd_reg : LNK_NULL;
    assign free_nxt = fsel_reg ? frd_reg :
                      ((free_head_reg[4:0] == 5'(NUM_DESC - 1)) ? LNK_NULL
                                                             : {1'b0, free_head_reg[4:0] + 5'd1});

    always_ff @(posedge clk)
    begin
        drd_reg  <= desc_mem[d_ra];
        brd_reg  <= bkt_mem[hash_reg];
        bsel_reg <= bvalid_reg[hash_reg];
        frd_reg  <= free_mem[free_head_reg[4:0]];
        fsel_reg <= fvalid_reg[free_head_reg[4:0]];
        pnrd_reg <= pn_mem[q_reg];
        pprd_reg <= pp_mem[q_reg];
        pdrd_reg <= pd_mem[q_reg];
        if (d_we)
        begin
            desc_mem[d_wa] <= d_wd;
        end
        if (b_we)
        begin
            bkt_mem[hash_reg] <= b_wd;
        end
        if (f_we)
        begin
            free_mem[d_reg] <= free_head_reg;
        end
        if (pn_we)
        begin
            pn_mem[pn_wa] <= pn_wd;
        end
        if (pp_we)
        begin
            pp_mem[pp_wa] <= pp_wd;
        end
        if (pd_we)
        begin
            pd_mem[q_reg] <= d_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_head_reg <= 6'd0;
            in_use_reg    <= '0;
            blocked_reg   <= '0;
            bvalid_reg    <= '0;
            fvalid_reg    <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            in_use_reg    <= in_use_next;
            blocked_reg   <= blocked_next;
            bvalid_reg    <= bvalid_next;
            fvalid_reg    <= fvalid_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        key_reg  <= key_next;
        q_reg    <= q_next;
        d_reg    <= d_next;
        prev_reg <= prev_next;
        nx_reg   <= nx_next;
        pr_reg   <= pr_next;
        bkt_reg  <= bkt_next;
        rec_reg  <= rec_next;
        hash_reg <= hash_next;
        res_reg  <= res_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        q_next         = q_reg;
        d_next         = d_reg;
        prev_next      = prev_reg;
        nx_next        = nx_reg;
        pr_next        = pr_reg;
        bkt_next       = bkt_reg;
        rec_next       = rec_reg;
        hash_next      = hash_reg;
        free_head_next = free_head_reg;
        in_use_next    = in_use_reg;
        blocked_next   = blocked_reg;
        bvalid_next    = bvalid_reg;
        fvalid_next    = fvalid_reg;
        done_next      = 1'b0;
        res_next       = res_reg;
        d_ra  = d_reg;
        d_we  = 1'b0;
        d_wa  = d_reg;
        d_wd  = rec_reg;
        b_we  = 1'b0;
        b_wd  = LNK_NULL;
        f_we  = 1'b0;
        pn_we = 1'b0;
        pn_wa = q_reg;
        pn_wd = LNK_NULL;
        pp_we = 1'b0;
        pp_wa = q_reg;
        pp_wd = LNK_NULL;
        pd_we = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next   = cmd.opcode;
                    key_next  = cmd.sem_key;
                    q_next    = cmd.proc_id;
                    hash_next = prod[31:24];
                    if ((cmd.opcode == OP_BLOCK && blocked_reg[cmd.proc_id]) ||
                        (cmd.opcode == OP_RM_PROC && !blocked_reg[cmd.proc_id]))
                    begin
                        done_next  = 1'b1;
                        res_next   = '{status: ST_NOT_FOUND, proc_out: 5'd0};
                        state_next = S_IDLE;
                    end
                    else if (cmd.opcode == OP_RM_PROC)
                    begin
                        state_next = S_P0;
                    end
                    else
                    begin
                        state_next = S_BKT;
                    end
                end
            end
            S_BKT:
            begin
                state_next = S_LK0;
            end
            S_LK0:
            begin
                bkt_next = bkt_cur;
                if (bkt_cur[5])
                begin
                    if (op_reg == OP_BLOCK)
                    begin
                        state_next = S_AL0;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        res_next   = '{status: ST_NOT_FOUND, proc_out: 5'd0};
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    d_ra       = bkt_cur[4:0];
                    d_next     = bkt_cur[4:0];
                    state_next = S_LK1;
                end
            end
            S_LK1:
            begin
                if (drd_reg.key == key_reg)
                begin
                    rec_next = drd_reg;
                    if (op_reg == OP_BLOCK)
                    begin
                        state_next = S_EQ;
                    end
                    else if (drd_reg.head[5])
                    begin
                        done_next  = 1'b1;
                        res_next   = '{status: ST_NOT_FOUND, proc_out: 5'd0};
                        state_next = S_IDLE;
                    end
                    else if (op_reg == OP_PEEK)
                    begin
                        done_next  = 1'b1;
                        res_next   = '{status: ST_OK, proc_out: drd_reg.head[4:0]};
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        q_next     = drd_reg.head[4:0];
                        state_next = S_P0;
                    end
                end
                else if (drd_reg.chain[5])
                begin
                    if (op_reg == OP_BLOCK)
                    begin
                        state_next = S_AL0;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        res_next   = '{status: ST_NOT_FOUND, proc_out: 5'd0};
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    d_ra   = drd_reg.chain[4:0];
                    d_next = drd_reg.chain[4:0];
                end
            end
            S_AL0:
            begin
                if (free_head_reg[5])
                begin
                    done_next  = 1'b1;
                    res_next   = '{status: ST_NO_FREE, proc_out: 5'd0};
                    state_next = S_IDLE;
                end
                else
                begin
                    d_next     = free_head_reg[4:0];
                    state_next = S_AL1;
                end
            end
            S_AL1:
            begin
                free_head_next     = free_nxt;
                in_use_next[d_reg] = 1'b1;
                blocked_next[q_reg] = 1'b1;
                d_we  = 1'b1;
                d_wd  = '{key: key_reg, head: {1'b0, q_reg}, tail: {1'b0, q_reg},
                          chain: bkt_reg};
                b_we  = 1'b1;
                b_wd  = {1'b0, d_reg};
                bvalid_next[hash_reg] = 1'b1;
                pn_we = 1'b1;
                pp_we = 1'b1;
                pd_we = 1'b1;
                done_next  = 1'b1;
                res_next   = '{status: ST_OK, proc_out: 5'd0};
                state_next = S_IDLE;
            end
            S_EQ:
            begin
                blocked_next[q_reg] = 1'b1;
                pn_we = 1'b1;
                pp_we = 1'b1;
                pp_wd = rec_reg.tail;
                pd_we = 1'b1;
                d_we  = 1'b1;
                d_wd  = rec_reg;
                d_wd.tail = {1'b0, q_reg};
                if (rec_reg.head[5] || rec_reg.tail[5])
                begin
                    d_wd.head  = {1'b0, q_reg};
                    done_next  = 1'b1;
                    res_next   = '{status: ST_OK, proc_out: 5'd0};
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_EQ2;
                end
            end
            S_EQ2:
            begin
                pn_we = 1'b1;
                pn_wa = rec_reg.tail[4:0];
                pn_wd = {1'b0, q_reg};
                done_next  = 1'b1;
                res_next   = '{status: ST_OK, proc_out: 5'd0};
                state_next = S_IDLE;
            end
            S_P0:
            begin
                state_next = S_P1;
            end
            S_P1:
            begin
                nx_next = pnrd_reg;
                pr_next = pprd_reg;
                if (op_reg == OP_RM_PROC)
                begin
                    if (!in_use_reg[pdrd_reg])
                    begin
                        done_next  = 1'b1;
                        res_next   = '{status: ST_NOT_FOUND, proc_out: 5'd0};
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        d_ra       = pdrd_reg;
                        d_next     = pdrd_reg;
                        state_next = S_P2;
                    end
                end
                else
                begin
                    state_next = S_UL;
                end
            end
            S_P2:
            begin
                rec_next   = drd_reg;
                state_next = S_UL;
            end
            S_UL:
            begin
                blocked_next[q_reg] = 1'b0;
                rec_next = rec_reg;
                if (!pr_reg[5])
                begin
                    pn_we = 1'b1;
                    pn_wa = pr_reg[4:0];
                    pn_wd = nx_reg;
                end
                else
                begin
                    rec_next.head = nx_reg;
                end
                if (!nx_reg[5])
                begin
                    pp_we = 1'b1;
                    pp_wa = nx_reg[4:0];
                    pp_wd = pr_reg;
                end
                else
                begin
                    rec_next.tail = pr_reg;
                end
                if (!rec_next.head[5])
                begin
                    d_we       = 1'b1;
                    d_wd       = rec_next;
                    done_next  = 1'b1;
                    res_next   = '{status: ST_OK, proc_out: q_reg};
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_RH;
                end
            end
            S_RH:
            begin
                hash_next  = prod[31:24];
                state_next = S_RB;
            end
            S_RB:
            begin
                state_next = S_RW0;
            end
            S_RW0:
            begin
                if (bkt_cur == {1'b0, d_reg})
                begin
                    b_we = 1'b1;
                    b_wd = rec_reg.chain;
                    state_next = S_FR;
                end
                else if (bkt_cur[5])
                begin
                    state_next = S_FR;
                end
                else
                begin
                    d_ra       = bkt_cur[4:0];
                    prev_next  = bkt_cur[4:0];
                    state_next = S_RW1;
                end
            end
            S_RW1:
            begin
                if (drd_reg.chain == {1'b0, d_reg})
                begin
                    d_we = 1'b1;
                    d_wa = prev_reg;
                    d_wd = drd_reg;
                    d_wd.chain = rec_reg.chain;
                    state_next = S_FR;
                end
                else if (drd_reg.chain[5])
                begin
                    state_next = S_FR;
                end
                else
                begin
                    d_ra      = drd_reg.chain[4:0];
                    prev_next = drd_reg.chain[4:0];
                end
            end
            S_FR:
            begin
                in_use_next[d_reg] = 1'b0;
                f_we               = 1'b1;
                fvalid_next[d_reg] = 1'b1;
                free_head_next     = {1'b0, d_reg};
                done_next  = 1'b1;
                res_next   = '{status: ST_OK, proc_out: q_reg};
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    `SWQT_ASSERT_SAME(a_done_idle, done, !busy, "Result transfer while busy.")
    `SWQT_ASSERT_NEXT(a_start_busy, start && !busy, busy || done,
        "Accepted transfer did not start work.")
    `SWQT_ASSERT_SAME(a_fail_zero, done && (result.status != ST_OK), result.proc_out == 5'd0,
        "Failed operation returned a process number.")
    `SWQT_ASSERT_SAME(a_free_empty, free_head_reg[5], &in_use_reg,
        "Free list empty while a descriptor is unused.")

endmodule
